FILE: src/akf_pkg.sv
// shared types and constants for the angle kalman filter
package akf_pkg;

    localparam int COV_FRAC_BITS   = 30;
    localparam int MAX_INTERVAL_MS = 1000;

    localparam logic [30:0] QA_RESET = 31'd1073742;
    localparam logic [30:0] QB_RESET = 31'd322123;
    localparam logic [30:0] RM_RESET = 31'd32212255;

    localparam logic [1:0] REG_QA = 2'd0;
    localparam logic [1:0] REG_QB = 2'd1;
    localparam logic [1:0] REG_RM = 2'd2;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    // dt = ms * floor(2^30 / 1000) + round(ms * 103 / 125), the last term by reciprocal
    localparam logic [20:0] DT_INT         = 21'd1073741;
    localparam logic [6:0]  DT_FRAC_NUM    = 7'd103;
    localparam logic [5:0]  DT_FRAC_HALF   = 6'd62;
    localparam logic [17:0] DT_RECIP       = 18'd134218;
    localparam int          DT_RECIP_SHIFT = 24;

    // quotient bits per division
    localparam logic [5:0] DIV_STEPS = 6'd31;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DT,
        ST_DIFF,
        ST_ANG_P,
        ST_T,
        ST_INNER,
        ST_P00,
        ST_PB,
        ST_S,
        ST_DIV0,
        ST_DIV0_RUN,
        ST_DIV1,
        ST_DIV1_RUN,
        ST_INNOV,
        ST_ANG_C,
        ST_BIAS_C,
        ST_P00_C,
        ST_P01_C,
        ST_P10_C,
        ST_P11_C,
        ST_OUT
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'(S32_MAX))
            return S32_MAX;
        else if (v < 66'(S32_MIN))
            return S32_MIN;
        else
            return v[31:0];
    endfunction

endpackage

FILE: src/angle_kalman_filter.sv
// top level: two-state angle kalman filter with one shared multiplier and a serial divider
// the sequencer runs 16 steps plus two divisions, each a setup step, 31 quotient bits
//   at one bit per cycle and a rounding step
// a new input is taken only in idle, after the last result has been loaded; a result that
//   is still waiting holds the sequencer in its last step until it transfers
// reset clears the estimates and covariance and loads the default noise values
module angle_kalman_filter (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [31:0]  measured_angle,
    input  logic signed [31:0]  gyro_rate,
    input  logic [9:0]          interval_ms,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  filtered_angle,
    output logic signed [31:0]  rate_bias
);
    import akf_pkg::*;

    state_t state_reg, state_next;

    logic [30:0] qa_reg, qb_reg, rm_reg;
    logic signed [31:0] ang_reg, bias_reg, p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [31:0] meas_reg, rate_reg, dt_reg, a_reg, t_reg, s_reg, k0_reg, k1_reg;
    logic [9:0]  ms_reg;
    logic        out_valid_reg;
    logic signed [31:0] fa_reg, rb_reg;
    logic        out_load;

    // interval scaling
    logic [30:0] dt_hi;
    logic [16:0] dt_x;
    logic [34:0] dt_fp;
    logic [31:0] dt_val;

    // serial divider
    logic [31:0] rem_reg;
    logic [31:0] dsr_reg;
    logic [30:0] quo_reg;
    logic [5:0]  cnt_reg;
    logic        dneg_reg;
    logic        ovf_reg;
    logic signed [31:0] div_num;
    logic [31:0] div_num_mag, div_den_mag;
    logic [32:0] div_trial;
    logic        div_bit;
    logic [31:0] div_qs;
    logic signed [31:0] div_res;

    // shared multiplier
    logic signed [31:0] ma, mb, mq;
    logic [63:0] mprod;
    logic [33:0] mrnd;
    logic        mneg;

    logic [1:0] widx;
    logic cfg_wr;

    assign pready = 1'b1;
    assign widx   = paddr[3:2];
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        case (widx)
            REG_QA:  prdata = {1'b0, qa_reg};
            REG_QB:  prdata = {1'b0, qb_reg};
            REG_RM:  prdata = {1'b0, rm_reg};
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qa_reg <= QA_RESET;
            qb_reg <= QB_RESET;
            rm_reg <= RM_RESET;
        end
        else if (cfg_wr)
        begin
            case (widx)
                REG_QA:  qa_reg <= pwdata[30:0];
                REG_QB:  qb_reg <= pwdata[30:0];
                REG_RM:  rm_reg <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    // multiplier operand select
    always_comb
    begin
        ma = dt_reg;
        mb = a_reg;
        case (state_reg)
            ST_ANG_P, ST_T, ST_P00: ma = dt_reg;
            ST_PB:                  ma = $signed({1'b0, qb_reg});
            ST_ANG_C, ST_P00_C, ST_P01_C: ma = k0_reg;
            ST_BIAS_C, ST_P10_C, ST_P11_C: ma = k1_reg;
            default:                ma = dt_reg;
        endcase
        case (state_reg)
            ST_ANG_P, ST_P00, ST_ANG_C, ST_BIAS_C: mb = a_reg;
            ST_T, ST_PB:           mb = p11_reg;
            ST_P00_C, ST_P10_C:    mb = p00_reg;
            ST_P01_C, ST_P11_C:    mb = p01_reg;
            default:               mb = a_reg;
        endcase
        if (state_reg == ST_PB)
            mb = dt_reg;
    end

    always_comb
    begin
        logic [31:0] am, bm;
        am    = ma[31] ? 32'(-ma) : 32'(ma);
        bm    = mb[31] ? 32'(-mb) : 32'(mb);
        mneg  = ma[31] ^ mb[31];
        mprod = 64'(am) * 64'(bm);
        mrnd  = 34'((mprod + (64'd1 << (COV_FRAC_BITS - 1))) >> COV_FRAC_BITS);
        mq    = mneg ? sat32(-$signed({32'd0, mrnd})) : sat32($signed({32'd0, mrnd}));
    end

    // dt = round(ms * 2^30 / 1000) split into an integer multiple and a small remainder term
    always_comb
    begin
        dt_hi  = 31'(ms_reg) * 31'(DT_INT);
        dt_x   = 17'(ms_reg) * 17'(DT_FRAC_NUM) + 17'(DT_FRAC_HALF);
        dt_fp  = 35'(dt_x) * 35'(DT_RECIP);
        dt_val = 32'(dt_hi) + 32'(dt_fp >> DT_RECIP_SHIFT);
    end

    // divider datapath: magnitudes for setup, one restoring step, rounding and sign at the end
    always_comb
    begin
        div_num     = (state_reg == ST_DIV0) ? p00_reg : p10_reg;
        div_num_mag = div_num[31] ? 32'(-div_num) : 32'(div_num);
        div_den_mag = s_reg[31] ? 32'(-s_reg) : 32'(s_reg);
        // first step takes the integer bit, later steps shift the remainder
        div_trial   = (cnt_reg == DIV_STEPS) ? {1'b0, rem_reg} : {rem_reg, 1'b0};
        div_bit     = (div_trial >= {1'b0, dsr_reg});
        div_qs      = {1'b0, quo_reg} + 32'({rem_reg, 1'b0} >= {1'b0, dsr_reg});
        if (ovf_reg)
            div_qs = 32'h8000_0000;
        if (dsr_reg == 32'd0)
            div_res = S32_MAX;
        else if (dneg_reg)
            div_res = sat32(-$signed({34'd0, div_qs}));
        else
            div_res = sat32($signed({34'd0, div_qs}));
    end

    assign out_load = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (in_valid) state_next = ST_DT;
            ST_DT:       state_next = ST_DIFF;
            ST_DIFF:     state_next = ST_ANG_P;
            ST_ANG_P:    state_next = ST_T;
            ST_T:        state_next = ST_INNER;
            ST_INNER:    state_next = ST_P00;
            ST_P00:      state_next = ST_PB;
            ST_PB:       state_next = ST_S;
            ST_S:        state_next = ST_DIV0;
            ST_DIV0:     state_next = ST_DIV0_RUN;
            ST_DIV0_RUN: if (cnt_reg == 6'd0) state_next = ST_DIV1;
            ST_DIV1:     state_next = ST_DIV1_RUN;
            ST_DIV1_RUN: if (cnt_reg == 6'd0) state_next = ST_INNOV;
            ST_INNOV:    state_next = ST_ANG_C;
            ST_ANG_C:    state_next = ST_BIAS_C;
            ST_BIAS_C:   state_next = ST_P00_C;
            ST_P00_C:    state_next = ST_P01_C;
            ST_P01_C:    state_next = ST_P10_C;
            ST_P10_C:    state_next = ST_P11_C;
            ST_P11_C:    state_next = ST_OUT;
            ST_OUT:      if (out_load) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall = (state_reg != ST_IDLE);
    end

    assign out_valid      = out_valid_reg;
    assign filtered_angle = fa_reg;
    assign rate_bias      = rb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            ang_reg  <= '0;
            bias_reg <= '0;
            p00_reg  <= '0;
            p01_reg  <= '0;
            p10_reg  <= '0;
            p11_reg  <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && out_load)
            begin
                fa_reg        <= ang_reg;
                rb_reg        <= bias_reg;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                    if (in_valid)
                    begin
                        meas_reg <= measured_angle;
                        rate_reg <= gyro_rate;
                        ms_reg   <= (interval_ms > 10'(MAX_INTERVAL_MS)) ?
                                    10'(MAX_INTERVAL_MS) : interval_ms;
                    end
                ST_DT:
                    dt_reg <= dt_val;
                ST_DIFF:
                    a_reg <= sat32(66'(rate_reg) - 66'(bias_reg));
                ST_ANG_P:
                    ang_reg <= sat32(66'(ang_reg) + 66'(mq));
                ST_T:
                    t_reg <= mq;
                ST_INNER:
                    a_reg <= sat32(66'(t_reg) - 66'(p01_reg) - 66'(p10_reg)
                                   + 66'(qa_reg));
                ST_P00:
                begin
                    p00_reg <= sat32(66'(p00_reg) + 66'(mq));
                    p01_reg <= sat32(66'(p01_reg) - 66'(t_reg));
                    p10_reg <= sat32(66'(p10_reg) - 66'(t_reg));
                end
                ST_PB:
                    p11_reg <= sat32(66'(p11_reg) + 66'(mq));
                ST_S:
                    s_reg <= sat32(66'(p00_reg) + 66'(rm_reg));
                ST_DIV0, ST_DIV1:
                begin
                    rem_reg  <= div_num_mag;
                    dsr_reg  <= div_den_mag;
                    dneg_reg <= div_num[31] ^ s_reg[31];
                    // quotient is at least 2^31 when the numerator is at least twice the divisor
                    ovf_reg  <= ({1'b0, div_num_mag} >= {div_den_mag, 1'b0});
                    quo_reg  <= '0;
                    cnt_reg  <= DIV_STEPS;
                end
                ST_DIV0_RUN, ST_DIV1_RUN:
                begin
                    if (cnt_reg != 6'd0)
                    begin
                        cnt_reg <= cnt_reg - 6'd1;
                        rem_reg <= div_bit ? 32'(div_trial - {1'b0, dsr_reg})
                                           : 32'(div_trial);
                        quo_reg <= {quo_reg[29:0], div_bit};
                    end
                    else if (state_reg == ST_DIV0_RUN)
                        k0_reg <= div_res;
                    else
                        k1_reg <= div_res;
                end
                ST_INNOV:
                    a_reg <= sat32(66'(meas_reg) - 66'(ang_reg));
                ST_ANG_C:
                    ang_reg <= sat32(66'(ang_reg) + 66'(mq));
                ST_BIAS_C:
                    bias_reg <= sat32(66'(bias_reg) + 66'(mq));
                ST_P00_C:
                    t_reg <= mq;
                ST_P01_C:
                    a_reg <= mq;
                ST_P10_C:
                begin
                    p10_reg <= sat32(66'(p10_reg) - 66'(mq));
                    p00_reg <= sat32(66'(p00_reg) - 66'(t_reg));
                end
                ST_P11_C:
                begin
                    // p01 is corrected only in this step so the last product still sees its old value
                    p11_reg <= sat32(66'(p11_reg) - 66'(mq));
                    p01_reg <= sat32(66'(p01_reg) - 66'(a_reg));
                end
                default: ;
            endcase
        end
    end

endmodule
